[src/ipr_rows_pkg.sv]
// Shared types, constants and the row filter for the isolated pixel removal block.
package ipr_rows_pkg;

  localparam int HALF_W    = 64;
  localparam int FULL_W    = 2 * HALF_W;
  localparam int ROW_WIDTH = 128;
  localparam int ROW_COUNT = 32;
  localparam int ROW_NUM_W = 5;

  // Result queue geometry: room for a frame's double result plus slack.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef logic [FULL_W-1:0] row_t;

  localparam row_t ROW_MASK = {FULL_W{1'b1}} >> (FULL_W - ROW_WIDTH);
  localparam logic [ROW_NUM_W-1:0] LAST_ROW = ROW_NUM_W'(ROW_COUNT - 1);

  typedef struct packed {
    logic [HALF_W-1:0] marked_low;
    logic [HALF_W-1:0] marked_high;
  } in_req_t;

  typedef struct packed {
    logic [HALF_W-1:0]    lit_low;
    logic [HALF_W-1:0]    lit_high;
    logic [ROW_NUM_W-1:0] row_number;
    logic                 frame_done;
  } out_req_t;

  // Keep a marked centre pixel only when some in-frame neighbour is marked.
  function automatic row_t filter_row(row_t up, row_t mid, row_t down);
    row_t span;
    span = up | mid | down;
    return mid & (up | down | (span << 1) | (span >> 1)) & ROW_MASK;
  endfunction

endpackage

[src/isolated_pixel_removal_rows_core.sv]
// Top level of the isolated pixel removal block: row window, filter and result queue.
//
// Takes one 128-pixel row per request and, with a two-row window, gives the filtered
// result for the row before it: a pixel stays set only when it is marked and at least
// one of its eight neighbours inside the frame is marked. The first row of a frame
// gives no result; the last row (ROW_COUNT-1) gives two, the previous row and then
// itself with frame_done set, and clears the window for the next frame. Rows are
// filtered in the cycle they are accepted and the results land in a four-entry
// result queue, so a row can be taken every cycle while in_ready is high and
// earlier results wait. in_ready is high whenever the queue holds at most two
// results. With a sink that takes one result per cycle, input runs at one row per
// cycle with no stall: the first row of each frame gives no result, which leaves
// room on the single result port for the last row's pair. Each result is registered
// in the queue before it reaches out_req.
module isolated_pixel_removal_rows_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ipr_rows_pkg::in_req_t   in_req,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ipr_rows_pkg::out_req_t  out_req
);

  // Window and frame position.
  ipr_rows_pkg::row_t                 above_r, above_nxt;
  ipr_rows_pkg::row_t                 center_r, center_nxt;
  logic [ipr_rows_pkg::ROW_NUM_W-1:0] rows_seen_r, rows_seen_nxt;

  // Result queue.
  ipr_rows_pkg::out_req_t             queue_r [ipr_rows_pkg::Q_DEPTH];
  logic [ipr_rows_pkg::Q_PTR_W-1:0]   wptr_r, wptr_nxt, wptr_p1;
  logic [ipr_rows_pkg::Q_PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [ipr_rows_pkg::Q_CNT_W-1:0]   count_r, count_nxt;

  ipr_rows_pkg::row_t                 incoming;
  ipr_rows_pkg::out_req_t             res_prev, res_last;
  logic                               in_fire, out_fire;
  logic                               first_row, last_row;
  logic                               wr_prev, wr_last;

  assign in_ready  = (count_r <= ipr_rows_pkg::Q_CNT_W'(ipr_rows_pkg::Q_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_req   = queue_r[rptr_r];
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign wptr_p1   = wptr_r + ipr_rows_pkg::Q_PTR_W'(1);

  // Drop columns beyond the frame width before anything sees them.
  assign incoming  = {in_req.marked_high, in_req.marked_low} & ipr_rows_pkg::ROW_MASK;
  assign first_row = (rows_seen_r == '0);
  assign last_row  = (rows_seen_r >= ipr_rows_pkg::LAST_ROW);

  always_comb begin
    ipr_rows_pkg::row_t prev_bits;
    ipr_rows_pkg::row_t last_bits;
    prev_bits = ipr_rows_pkg::filter_row(above_r, center_r, incoming);
    last_bits = ipr_rows_pkg::filter_row(center_r, incoming, '0);

    res_prev.lit_low    = prev_bits[ipr_rows_pkg::HALF_W-1:0];
    res_prev.lit_high   = prev_bits[ipr_rows_pkg::FULL_W-1:ipr_rows_pkg::HALF_W];
    res_prev.row_number = rows_seen_r - ipr_rows_pkg::ROW_NUM_W'(1);
    res_prev.frame_done = 1'b0;

    res_last.lit_low    = last_bits[ipr_rows_pkg::HALF_W-1:0];
    res_last.lit_high   = last_bits[ipr_rows_pkg::FULL_W-1:ipr_rows_pkg::HALF_W];
    res_last.row_number = rows_seen_r;
    res_last.frame_done = 1'b1;
  end

  always_comb begin
    wr_prev       = in_fire && !first_row;
    wr_last       = in_fire && !first_row && last_row;
    above_nxt     = above_r;
    center_nxt    = center_r;
    rows_seen_nxt = rows_seen_r;

    if (in_fire) begin
      if (first_row) begin
        // Open the frame: nothing above the top row.
        above_nxt     = '0;
        center_nxt    = incoming;
        rows_seen_nxt = ipr_rows_pkg::ROW_NUM_W'(1);
      end else if (last_row) begin
        // Flush the window and start over.
        above_nxt     = '0;
        center_nxt    = '0;
        rows_seen_nxt = '0;
      end else begin
        // Advance the window one row down.
        above_nxt     = center_r;
        center_nxt    = incoming;
        rows_seen_nxt = rows_seen_r + ipr_rows_pkg::ROW_NUM_W'(1);
      end
    end

    wptr_nxt  = wptr_r + ipr_rows_pkg::Q_PTR_W'(wr_prev) + ipr_rows_pkg::Q_PTR_W'(wr_last);
    rptr_nxt  = rptr_r + ipr_rows_pkg::Q_PTR_W'(out_fire);
    count_nxt = count_r + ipr_rows_pkg::Q_CNT_W'(wr_prev) + ipr_rows_pkg::Q_CNT_W'(wr_last)
                - ipr_rows_pkg::Q_CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_seen_r <= '0;
      wptr_r      <= '0;
      rptr_r      <= '0;
      count_r     <= '0;
    end else begin
      rows_seen_r <= rows_seen_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      count_r     <= count_nxt;
    end
  end

  // Window rows are rewritten on the first row of every frame, so they need no reset.
  always_ff @(posedge clk) begin
    above_r  <= above_nxt;
    center_r <= center_nxt;
  end

  // Hold results; the last row's own result goes in the slot after the previous row's.
  always_ff @(posedge clk) begin
    if (wr_prev) begin
      queue_r[wptr_r] <= res_prev;
    end
    if (wr_last) begin
      queue_r[wptr_p1] <= res_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ipr_rows_pkg::Q_CNT_W'(ipr_rows_pkg::Q_DEPTH))
    else $error("result queue overfilled");

  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_seen_r <= ipr_rows_pkg::LAST_ROW)
    else $error("row counter past the last row");

  a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_row && !first_row && !out_fire |=>
      count_r == $past(count_r) + ipr_rows_pkg::Q_CNT_W'(2))
    else $error("last row did not queue two results");

  a_done_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.frame_done |-> out_req.row_number == ipr_rows_pkg::LAST_ROW)
    else $error("frame_done on a row other than the last");

  a_edge_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({out_req.lit_high, out_req.lit_low} & ~ipr_rows_pkg::ROW_MASK) == '0)
    else $error("result bit set beyond the frame width");

endmodule

[dv/isolated_pixel_removal_rows_checker.sv]
// Checker for the isolated pixel removal block: row window prediction and result comparison.
module isolated_pixel_removal_rows_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  ipr_rows_pkg::in_req_t  in_req,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  ipr_rows_pkg::out_req_t out_req,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int REPORT_CAP = 40;

  ipr_rows_pkg::row_t                 above_rows;
  ipr_rows_pkg::row_t                 centre_rows;
  logic [ipr_rows_pkg::ROW_NUM_W-1:0] rows_taken;
  ipr_rows_pkg::out_req_t             lit_rows_due[$];
  int                                 reports;

  // Column by column: keep a marked pixel when any in-frame neighbour is marked.
  function automatic ipr_rows_pkg::row_t surviving_pixels(ipr_rows_pkg::row_t up,
                                                          ipr_rows_pkg::row_t mid,
                                                          ipr_rows_pkg::row_t down);
    ipr_rows_pkg::row_t lit;
    logic near;
    int   c;
    lit = '0;
    for (c = 0; c < ipr_rows_pkg::ROW_WIDTH; c++) begin
      near = up[c] | down[c];
      if (c > 0) near = near | up[c-1] | mid[c-1] | down[c-1];
      if (c < ipr_rows_pkg::ROW_WIDTH - 1) near = near | up[c+1] | mid[c+1] | down[c+1];
      lit[c] = mid[c] & near;
    end
    return lit;
  endfunction

  function automatic ipr_rows_pkg::out_req_t make_result(
      ipr_rows_pkg::row_t lit, logic [ipr_rows_pkg::ROW_NUM_W-1:0] idx, logic last);
    ipr_rows_pkg::out_req_t r;
    r.lit_low    = lit[ipr_rows_pkg::HALF_W-1:0];
    r.lit_high   = lit[ipr_rows_pkg::FULL_W-1:ipr_rows_pkg::HALF_W];
    r.row_number = idx;
    r.frame_done = last;
    return r;
  endfunction

  task automatic take_row(input ipr_rows_pkg::in_req_t req);
    ipr_rows_pkg::row_t incoming;
    incoming = {req.marked_high, req.marked_low};
    if (rows_taken == '0) begin
      above_rows  = '0;
      centre_rows = incoming;
      rows_taken  = ipr_rows_pkg::ROW_NUM_W'(1);
    end else begin
      lit_rows_due.push_back(make_result(surviving_pixels(above_rows, centre_rows, incoming),
                                         rows_taken - 1'b1, 1'b0));
      if (rows_taken >= ipr_rows_pkg::LAST_ROW) begin
        lit_rows_due.push_back(make_result(surviving_pixels(centre_rows, incoming, '0),
                                           rows_taken, 1'b1));
        above_rows  = '0;
        centre_rows = '0;
        rows_taken  = '0;
      end else begin
        above_rows  = centre_rows;
        centre_rows = incoming;
        rows_taken  = rows_taken + 1'b1;
      end
    end
  endtask

  task automatic report(input string field, input logic [ipr_rows_pkg::HALF_W-1:0] want,
                        input logic [ipr_rows_pkg::HALF_W-1:0] got);
    mismatches++;
    if (reports < REPORT_CAP) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      reports++;
    end
  endtask

  task automatic check_result(input ipr_rows_pkg::out_req_t got);
    ipr_rows_pkg::out_req_t want;
    if (lit_rows_due.size() == 0) begin
      mismatches++;
      if (reports < REPORT_CAP) begin
        $display("%0t: unexpected result, expected none, actual row %0d lit %h_%h",
                 $time, got.row_number, got.lit_high, got.lit_low);
        reports++;
      end
    end else begin
      want = lit_rows_due.pop_front();
      if (got.lit_low !== want.lit_low) report("lit_low", want.lit_low, got.lit_low);
      if (got.lit_high !== want.lit_high) report("lit_high", want.lit_high, got.lit_high);
      if (got.row_number !== want.row_number)
        report("row_number", ipr_rows_pkg::HALF_W'(want.row_number),
               ipr_rows_pkg::HALF_W'(got.row_number));
      if (got.frame_done !== want.frame_done)
        report("frame_done", ipr_rows_pkg::HALF_W'(want.frame_done),
               ipr_rows_pkg::HALF_W'(got.frame_done));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      above_rows  = '0;
      centre_rows = '0;
      rows_taken  = '0;
      mismatches  = 0;
      reports     = 0;
      lit_rows_due.delete();
    end else begin
      // Compare first so a result can never match a request taken on the same edge.
      if (out_valid && out_ready) check_result(out_req);
      if (in_valid && in_ready) take_row(in_req);
    end
    outstanding = lit_rows_due.size();
  end

endmodule

[dv/tb_isolated_pixel_removal_rows_core.sv]
// Testbench top for the isolated pixel removal block: stimulus, pacing and verdict.
module tb_isolated_pixel_removal_rows_core;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_ROWS     = 1128;
  localparam int DRAIN_AT_ROW    = 500;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_CYCLES = 700000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  ipr_rows_pkg::in_req_t  in_req = '0;
  ipr_rows_pkg::out_req_t out_req;

  int   mismatches;
  int   outstanding;
  logic sender_eager = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  isolated_pixel_removal_rows_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

  isolated_pixel_removal_rows_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_req     (out_req),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Pause length in cycles: mostly none, often short, now and then long.
  function automatic int pause_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [127:0] one_hot(input int col);
    return 128'(1) << col;
  endfunction

  // Random row: dense noise, thinned masks down to a few pixels per row, and a share of
  // empty, full and single-pixel rows so that isolated pixels turn up often.
  function automatic logic [127:0] random_pixels();
    logic [127:0] bits;
    int           kind;
    int           thinning;
    bits = {$urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      bits = '0;
    end else if (kind < 8) begin
      bits = '1;
    end else if (kind < 18) begin
      bits = one_hot($urandom_range(0, 127));
    end else begin
      thinning = $urandom_range(0, 5);
      repeat (thinning) bits = bits & {$urandom, $urandom, $urandom, $urandom};
    end
    return bits;
  endfunction

  // Offer one row as a request and hold it until the block takes it. The valid line is
  // only lowered for a gap, so back-to-back requests keep it high across the edge.
  task automatic offer_row(input logic [127:0] pixels);
    ipr_rows_pkg::in_req_t req;
    int gap;
    gap = sender_eager ? 0 : pause_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.marked_low  = pixels[63:0];
    req.marked_high = pixels[127:64];
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has drained out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [127:0] probe [0:21];
    int n;

    // Directed rows, top of the first frame. Each row is judged against the rows
    // either side, so the patterns come in groups separated by empty rows.
    probe[0]  = '1;                            // full row on the top edge
    probe[1]  = '0;
    probe[2]  = one_hot(0);                    // lone pixel on the left edge
    probe[3]  = '0;
    probe[4]  = one_hot(63) | one_hot(64);     // horizontal pair across the halves
    probe[5]  = '0;
    probe[6]  = one_hot(0) | one_hot(127);     // both edges, must not wrap round
    probe[7]  = '0;
    probe[8]  = one_hot(63);                   // diagonal pair across the halves
    probe[9]  = one_hot(64);
    probe[10] = '0;
    probe[11] = one_hot(10);                   // vertical pair
    probe[12] = one_hot(10);
    probe[13] = one_hot(11);                   // diagonal onto the pair above
    probe[14] = '0;
    probe[15] = {32{4'h5}};                    // every other pixel, all isolated
    probe[16] = '0;
    probe[17] = {32{4'hA}};                    // checkerboard: only diagonal contact
    probe[18] = {32{4'h5}};
    probe[19] = '1;
    probe[20] = one_hot(127);                  // right edge under a full row
    probe[21] = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < 22; n++) offer_row(probe[n]);
    wait_for_drain();

    // Random rows; frames simply run on, 32 rows each. Switch the sender between
    // flat-out and gappy now and then, and drain completely once part way through.
    for (n = 0; n < RANDOM_ROWS; n++) begin
      if (n % 97 == 0) sender_eager = ($urandom_range(0, 2) == 0);
      if (n == DRAIN_AT_ROW) wait_for_drain();
      offer_row(random_pixels());
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS isolated_pixel_removal_rows_core");
    end else begin
      $display("FAIL isolated_pixel_removal_rows_core");
    end
    $finish;
  end

  // Result side: stall at random, with eager stretches where the sink never stalls.
  initial begin : sink_pacing
    int   stall_left;
    int   cycles_in_mode;
    logic sink_eager;
    stall_left     = 0;
    cycles_in_mode = 0;
    sink_eager     = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (cycles_in_mode == 0) begin
        sink_eager     = ($urandom_range(0, 3) == 0);
        cycles_in_mode = $urandom_range(50, 300);
      end
      cycles_in_mode--;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!sink_eager) stall_left = pause_cycles();
      end
    end
  end

  // Drop the run if it hangs.
  initial begin : watchdog
    #(WATCHDOG_CYCLES * CLK_PERIOD);
    $display("FAIL isolated_pixel_removal_rows_core");
    $finish;
  end

endmodule

[filelist.f]
src/ipr_rows_pkg.sv
src/isolated_pixel_removal_rows_core.sv
dv/isolated_pixel_removal_rows_checker.sv
dv/tb_isolated_pixel_removal_rows_core.sv
